// ----- hw/rtl/hbr_pkg.sv -----
// Shared types, constants and helpers for the heart-rate detector.
// Used by the interfaces, controller, datapath, divider and top level.
package hbr_pkg;

  localparam int AverageDepthDefault = 5;
  localparam int SampleBitsDefault   = 18;

  localparam int SAMPLE_W = 18;
  localparam int TIME_W   = 32;
  localparam int BPM_W    = 16;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;

  // 60000 ms per minute in Q.8.
  localparam logic [DIV_NUM_W-1:0] RATE_NUMERATOR = 24'd15360000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWPASS_COEFF   = 3'd0,
    REG_HIGHPASS_COEFF  = 3'd1,
    REG_MIN_PEAK        = 3'd2,
    REG_REFRACTORY      = 3'd3,
    REG_MIN_INTERVAL    = 3'd4,
    REG_MAX_INTERVAL    = 3'd5,
    REG_MIN_VALID_BPM   = 3'd6,
    REG_MAX_VALID_BPM   = 3'd7
  } hbr_reg_t;

  typedef struct packed {
    logic [15:0] lowpass_coeff;
    logic [15:0] highpass_coeff;
    logic [17:0] min_peak_amplitude;
    logic [15:0] refractory_ms;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [7:0]  min_valid_bpm;
    logic [7:0]  max_valid_bpm;
  } hbr_cfg_t;

  typedef struct packed {
    logic load;
    logic lp_mul;
    logic lp_upd;
    logic hp_mul;
    logic hp_upd;
    logic rate_start;
    logic rate_store;
    logic avg_update;
    logic avg_start;
    logic avg_store;
    logic out_load;
  } hbr_cmd_t;

  typedef struct packed {
    logic beat;
    logic rate_ok;
    logic div_done;
  } hbr_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hbr_if.sv -----
// Ready/valid channel interfaces for samples in and results out.
// Depends on hbr_pkg for field widths.
interface hbr_sample_if;
  logic                          valid;
  logic                          ready;
  logic [hbr_pkg::SAMPLE_W-1:0]  green_sample;
  logic [hbr_pkg::TIME_W-1:0]    time_ms;
  logic                          restart;
  modport source (output valid, green_sample, time_ms, restart, input ready);
  modport sink (input valid, green_sample, time_ms, restart, output ready);
endinterface

interface hbr_result_if;
  logic                       valid;
  logic                       ready;
  logic                       beat;
  logic                       rate_valid;
  logic [hbr_pkg::BPM_W-1:0]  smoothed_bpm;
  modport source (output valid, beat, rate_valid, smoothed_bpm, input ready);
  modport sink (input valid, beat, rate_valid, smoothed_bpm, output ready);
endinterface

// ----- hw/rtl/hbr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on hbr_pkg for operand widths.
module hbr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hbr_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [hbr_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                            done,
  output logic [hbr_pkg::DIV_NUM_W-1:0]   quotient
);
  localparam int CNT_W = $clog2(hbr_pkg::DIV_NUM_W);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic [hbr_pkg::DIV_NUM_W-1:0]   num;
  logic [hbr_pkg::DIV_DEN_W-1:0]   den;
  logic [hbr_pkg::DIV_DEN_W-1:0]   rem;
  logic [hbr_pkg::DIV_DEN_W:0]     rem_sh;
  logic                            fits;

  assign rem_sh = {rem, num[hbr_pkg::DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(hbr_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[hbr_pkg::DIV_NUM_W-2:0], 1'b0};
      rem      <= fits ? rem_sh[hbr_pkg::DIV_DEN_W-1:0] - den
                       : rem_sh[hbr_pkg::DIV_DEN_W-1:0];
      quotient <= {quotient[hbr_pkg::DIV_NUM_W-2:0], fits};
    end
  end
endmodule

// ----- hw/rtl/hbr_ctrl.sv -----
// Sequencing state machine for one sample at a time and the result register valid.
// Depends on hbr_pkg for the command and status structs.
module hbr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hbr_pkg::hbr_status_t status,
  output hbr_pkg::hbr_cmd_t    cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LPMUL  = 11'b00000000010,
    S_LPUPD  = 11'b00000000100,
    S_HPMUL  = 11'b00000001000,
    S_HPUPD  = 11'b00000010000,
    S_CHECK  = 11'b00000100000,
    S_RDIV   = 11'b00001000000,
    S_AVG    = 11'b00010000000,
    S_ASTART = 11'b00100000000,
    S_ADIV   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LPMUL;
        end
      end
      S_LPMUL: begin
        cmd.lp_mul = 1'b1;
        state_next = S_LPUPD;
      end
      S_LPUPD: begin
        cmd.lp_upd = 1'b1;
        state_next = S_HPMUL;
      end
      S_HPMUL: begin
        cmd.hp_mul = 1'b1;
        state_next = S_HPUPD;
      end
      S_HPUPD: begin
        cmd.hp_upd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!status.beat) begin
          state_next = S_DONE;
        end else if (status.rate_ok) begin
          cmd.rate_start = 1'b1;
          state_next     = S_RDIV;
        end else begin
          state_next = S_AVG;
        end
      end
      S_RDIV: begin
        if (status.div_done) begin
          cmd.rate_store = 1'b1;
          state_next     = S_AVG;
        end
      end
      S_AVG: begin
        cmd.avg_update = 1'b1;
        state_next     = S_ASTART;
      end
      S_ASTART: begin
        cmd.avg_start = 1'b1;
        state_next    = S_ADIV;
      end
      S_ADIV: begin
        if (status.div_done) begin
          cmd.avg_store = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/hbr_datapath.sv -----
// Filter, beat detection, rate and moving-average datapath with a shared
// multiplier and divider. Depends on hbr_pkg and hbr_div.
module hbr_datapath #(
  parameter int AVERAGE_DEPTH = hbr_pkg::AverageDepthDefault,
  parameter int SAMPLE_BITS   = hbr_pkg::SampleBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hbr_pkg::hbr_cfg_t             cfg,
  input  hbr_pkg::hbr_cmd_t             cmd,
  output hbr_pkg::hbr_status_t          status,
  input  logic [hbr_pkg::SAMPLE_W-1:0]  green_sample,
  input  logic [hbr_pkg::TIME_W-1:0]    time_ms,
  input  logic                          restart,
  output logic                          beat,
  output logic                          rate_valid,
  output logic [hbr_pkg::BPM_W-1:0]     smoothed_bpm
);
  localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int N_W    = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W  = hbr_pkg::BPM_W + N_W;
  localparam logic [hbr_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= hbr_pkg::SAMPLE_W) ? '1 : hbr_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  logic [hbr_pkg::SAMPLE_W-1:0] sample;
  logic [hbr_pkg::TIME_W-1:0]   now;
  logic signed [31:0] lp, hip, hop, ssp, slope_prev;
  logic [31:0]        peak;
  logic [31:0]        last_beat;
  logic [15:0]        held;
  logic [15:0]        interval;
  logic [15:0]        win [AVERAGE_DEPTH];
  logic [SLOT_W-1:0]  slot;
  logic               full;
  logic [SUM_W-1:0]   sum;
  logic [N_W-1:0]     count;
  logic               beat_r, rate_ok_r;
  logic [15:0]        smooth;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod;
  logic signed [34:0] rounded;
  logic signed [31:0] lp_new, hp_new, diff;
  logic [31:0]        mag, peak_new, since;
  logic               crossing, beat_now;
  logic [SUM_W-1:0]   sum_new;
  logic [N_W-1:0]     count_new;
  logic               wrap;

  logic                            div_start, div_done;
  logic [hbr_pkg::DIV_NUM_W-1:0]   div_num, div_q;
  logic [hbr_pkg::DIV_DEN_W-1:0]   div_den;

  // Shared multiplier operands: low-pass error or high-pass sum.
  always_comb begin
    if (cmd.hp_mul) begin
      mul_a = 34'(hop) + 34'(lp) - 34'(hip);
      mul_b = {1'b0, cfg.highpass_coeff};
    end else begin
      mul_a = $signed({8'd0, sample & SAMPLE_MASK, 8'd0}) - 34'(lp);
      mul_b = {1'b0, cfg.lowpass_coeff};
    end
  end

  assign rounded = 35'((prod + 51'sd32768) >>> 16);
  assign lp_new  = hbr_pkg::sat32(40'(lp) + 40'(rounded));
  assign hp_new  = hbr_pkg::sat32(40'(rounded));
  assign diff    = hbr_pkg::sat32(40'(hp_new) - 40'(ssp));
  assign mag     = hp_new[31] ? 32'(-33'(hp_new)) : 32'(hp_new);
  assign peak_new = (mag > peak) ? mag : peak;
  assign crossing = (slope_prev > 0) && (diff <= 0);
  assign since    = now - last_beat;
  assign beat_now = crossing && (since > 32'(cfg.refractory_ms))
                 && (peak_new >= {6'd0, cfg.min_peak_amplitude, 8'd0});

  assign wrap      = (slot == SLOT_W'(AVERAGE_DEPTH - 1));
  assign sum_new   = sum - SUM_W'(win[slot]) + SUM_W'(held);
  assign count_new = (full || wrap) ? N_W'(AVERAGE_DEPTH) : N_W'(slot) + 1'b1;

  assign div_start = cmd.rate_start || cmd.avg_start;
  always_comb begin
    if (cmd.rate_start) begin
      div_num = hbr_pkg::RATE_NUMERATOR + hbr_pkg::DIV_NUM_W'(interval >> 1);
      div_den = interval;
    end else begin
      div_num = hbr_pkg::DIV_NUM_W'(sum) + hbr_pkg::DIV_NUM_W'(count >> 1);
      div_den = hbr_pkg::DIV_DEN_W'(count);
    end
  end

  hbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.beat     = beat_r;
  assign status.rate_ok  = rate_ok_r;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.lp_mul || cmd.hp_mul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.load) begin
      sample <= green_sample;
      now    <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.load && restart)) begin
      lp         <= '0;
      hip        <= '0;
      hop        <= '0;
      ssp        <= '0;
      slope_prev <= '0;
      peak       <= '0;
      last_beat  <= '0;
      held       <= '0;
      slot       <= '0;
      full       <= 1'b0;
      sum        <= '0;
      for (int i = 0; i < AVERAGE_DEPTH; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cmd.lp_upd) begin
        lp <= lp_new;
      end
      if (cmd.hp_upd) begin
        hip        <= lp;
        hop        <= hp_new;
        ssp        <= hp_new;
        slope_prev <= diff;
        peak       <= crossing ? 32'd0 : peak_new;
        if (beat_now) begin
          last_beat <= now;
        end
      end
      if (cmd.rate_store) begin
        held <= (div_q > 24'd65535) ? 16'hffff : div_q[15:0];
      end
      if (cmd.avg_update) begin
        win[slot] <= held;
        sum       <= sum_new;
        slot      <= wrap ? '0 : slot + 1'b1;
        full      <= full || wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hp_upd) begin
      beat_r    <= beat_now;
      rate_ok_r <= (since > 32'(cfg.min_interval_ms)) && (since < 32'(cfg.max_interval_ms));
      interval  <= since[15:0];
      smooth    <= '0;
    end
    if (cmd.avg_update) begin
      count <= count_new;
    end
    if (cmd.avg_store) begin
      smooth <= (div_q > 24'd65535) ? 16'hffff : div_q[15:0];
    end
    if (cmd.out_load) begin
      beat         <= beat_r;
      rate_valid   <= beat_r && (held > {cfg.min_valid_bpm, 8'd0})
                             && (held < {cfg.max_valid_bpm, 8'd0});
      smoothed_bpm <= smooth;
    end
  end
endmodule

// ----- hw/rtl/ppg_heartbeat_rate_detector.sv -----
// Top level of the PPG heart-rate detector: configuration registers,
// controller and datapath. Depends on hbr_pkg, hbr_if, hbr_ctrl, hbr_datapath.
//
// Usage: each request on the samples channel carries one green sample, its
// millisecond timestamp and a restart flag; each produces exactly one request
// on the results channel (beat flag, rate-valid flag, smoothed rate in Q8.8).
// Configuration is written through cfg_we / cfg_index / cfg_data, one register
// per cycle; the user writes it only while no sample is in flight, which the
// block does not enforce. Samples are handled one at a time. A sample that
// completes no beat runs only the load, filter and check states; a beat adds
// the averaging division, and the rate division before it when the rate is
// recomputed, each on the 24-step restoring divider. The next sample is
// accepted the cycle after the result is loaded into the output register.
// Reset (synchronous, rst high) loads the register defaults and clears the
// filter, peak, last-beat and window state; restart on a sample clears the
// same state except the registers. If the receiver stalls, the result
// register holds and the block finishes at most one more sample, then waits.
module ppg_heartbeat_rate_detector #(
  parameter int AVERAGE_DEPTH = hbr_pkg::AverageDepthDefault,
  parameter int SAMPLE_BITS   = hbr_pkg::SampleBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  hbr_sample_if.sink                    samples,
  hbr_result_if.source                  results,
  input  logic                          cfg_we,
  input  logic [hbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbr_pkg::CFG_W-1:0]     cfg_data
);
  hbr_pkg::hbr_cfg_t    cfg;
  hbr_pkg::hbr_cmd_t    cmd;
  hbr_pkg::hbr_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowpass_coeff      <= 16'd15667;
      cfg.highpass_coeff     <= 16'd63540;
      cfg.min_peak_amplitude <= 18'd40;
      cfg.refractory_ms      <= 16'd300;
      cfg.min_interval_ms    <= 16'd300;
      cfg.max_interval_ms    <= 16'd2000;
      cfg.min_valid_bpm      <= 8'd30;
      cfg.max_valid_bpm      <= 8'd200;
    end else if (cfg_we) begin
      case (hbr_pkg::hbr_reg_t'(cfg_index))
        hbr_pkg::REG_LOWPASS_COEFF:  cfg.lowpass_coeff      <= cfg_data[15:0];
        hbr_pkg::REG_HIGHPASS_COEFF: cfg.highpass_coeff     <= cfg_data[15:0];
        hbr_pkg::REG_MIN_PEAK:       cfg.min_peak_amplitude <= cfg_data;
        hbr_pkg::REG_REFRACTORY:     cfg.refractory_ms      <= cfg_data[15:0];
        hbr_pkg::REG_MIN_INTERVAL:   cfg.min_interval_ms    <= cfg_data[15:0];
        hbr_pkg::REG_MAX_INTERVAL:   cfg.max_interval_ms    <= cfg_data[15:0];
        hbr_pkg::REG_MIN_VALID_BPM:  cfg.min_valid_bpm      <= cfg_data[7:0];
        hbr_pkg::REG_MAX_VALID_BPM:  cfg.max_valid_bpm      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  hbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hbr_datapath #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .green_sample (samples.green_sample),
    .time_ms      (samples.time_ms),
    .restart      (samples.restart),
    .beat         (results.beat),
    .rate_valid   (results.rate_valid),
    .smoothed_bpm (results.smoothed_bpm)
  );

  // A sample that has been taken keeps the input closed while it is processed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("input accepted again while a sample is in flight");

  // A valid rate only comes with a beat.
  a_rate_needs_beat: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.rate_valid || results.beat))
    else $error("rate_valid without beat");

  // Without a beat the smoothed rate reads zero.
  a_no_beat_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.beat |-> results.smoothed_bpm == '0)
    else $error("nonzero smoothed rate without beat");
endmodule

// ----- dv/ppg_heartbeat_rate_detector_test.sv -----
// Self-checking testbench for ppg_heartbeat_rate_detector: pulse-train and noise samples
// are predicted in a scoreboard class and every result is compared field by field.
// Depends on hbr_pkg, hbr_if and the detector RTL.
module ppg_heartbeat_rate_detector_test;
  import hbr_pkg::*;

  typedef struct {
    bit          beat;
    bit          rate_valid;
    logic [15:0] smoothed_bpm;
  } beat_result_t;

  class beat_scoreboard;
    beat_result_t     awaited[$];
    int               mismatches;
    int               beats_seen;
    int               valid_seen;
    int               results_seen;
    logic [15:0]      lp_coeff, hp_coeff, refractory, min_interval, max_interval;
    logic [17:0]      min_peak;
    logic [7:0]       min_bpm, max_bpm;
    longint           lp, hp_in_prev, hp_out_prev, slope_src_prev, slope_last;
    longint           peak;
    logic [31:0]      last_beat;
    int unsigned      held_rate;
    int unsigned      window[5];
    int unsigned      slot;
    bit               full;
    int unsigned      rate_sum;

    function void clear_filters();
      lp = 0;
      hp_in_prev = 0;
      hp_out_prev = 0;
      slope_src_prev = 0;
      slope_last = 0;
      peak = 0;
      last_beat = 0;
      held_rate = 0;
      foreach (window[i]) window[i] = 0;
      slot = 0;
      full = 0;
      rate_sum = 0;
    endfunction

    function void reset_all();
      lp_coeff = 15667;
      hp_coeff = 63540;
      min_peak = 40;
      refractory = 300;
      min_interval = 300;
      max_interval = 2000;
      min_bpm = 30;
      max_bpm = 200;
      clear_filters();
    endfunction

    function void write_reg(hbr_reg_t idx, logic [17:0] val);
      case (idx)
        REG_LOWPASS_COEFF: lp_coeff = val[15:0];
        REG_HIGHPASS_COEFF: hp_coeff = val[15:0];
        REG_MIN_PEAK: min_peak = val;
        REG_REFRACTORY: refractory = val[15:0];
        REG_MIN_INTERVAL: min_interval = val[15:0];
        REG_MAX_INTERVAL: max_interval = val[15:0];
        REG_MIN_VALID_BPM: min_bpm = val[7:0];
        REG_MAX_VALID_BPM: max_bpm = val[7:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q0.16 product rounded to nearest, halves toward plus infinity.
    function longint round16(longint p);
      return (p + 32768) >>> 16;
    endfunction

    function void note_sample(logic [17:0] green, logic [31:0] now, logic restart);
      longint       x, hp, diff, mag;
      logic [31:0]  since;
      int unsigned  rate, n;
      beat_result_t e;
      e.beat = 0;
      e.rate_valid = 0;
      e.smoothed_bpm = 0;
      if (restart) clear_filters();
      x = longint'(green) <<< 8;
      lp = clip32(lp + round16((x - lp) * longint'(lp_coeff)));
      hp = clip32(round16((hp_out_prev + lp - hp_in_prev) * longint'(hp_coeff)));
      hp_in_prev = lp;
      hp_out_prev = hp;
      diff = clip32(hp - slope_src_prev);
      slope_src_prev = hp;
      mag = (hp < 0) ? -hp : hp;
      if (mag > peak) peak = mag;
      if (slope_last > 0 && diff <= 0) begin
        since = now - last_beat;
        if (since > {16'd0, refractory} && peak >= (longint'(min_peak) <<< 8)) e.beat = 1;
        peak = 0;
      end
      slope_last = diff;
      if (e.beat) begin
        since = now - last_beat;
        last_beat = now;
        if (since > {16'd0, min_interval} && since < {16'd0, max_interval}) begin
          rate = (15360000 + since / 2) / since;
          held_rate = (rate > 65535) ? 65535 : rate;
        end
        if (slot >= 5) slot = 0;
        rate_sum = rate_sum - window[slot] + held_rate;
        window[slot] = held_rate;
        slot++;
        if (slot >= 5) begin
          slot = 0;
          full = 1;
        end
        n = full ? 5 : slot;
        if (n == 0) n = 1;
        rate = (rate_sum + n / 2) / n;
        e.smoothed_bpm = (rate > 65535) ? 16'hffff : rate[15:0];
        e.rate_valid = held_rate > (int'(min_bpm) << 8) && held_rate < (int'(max_bpm) << 8);
      end
      awaited.push_back(e);
    endfunction

    function void check_result(bit beat, bit rate_valid, logic [15:0] bpm);
      beat_result_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no sample pending: beat=%0b", beat);
        return;
      end
      e = awaited.pop_front();
      if (beat) beats_seen++;
      if (rate_valid) valid_seen++;
      if (e.beat !== beat || e.rate_valid !== rate_valid || e.smoothed_bpm !== bpm) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected beat=%0b valid=%0b bpm=%0d, got %0b %0b %0d",
                   $realtime, e.beat, e.rate_valid, e.smoothed_bpm, beat, rate_valid, bpm);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  hbr_sample_if smp();
  hbr_result_if res();
  beat_scoreboard sb = new();
  int sent;
  bit calm;
  int stall_left;
  logic [31:0] clock_ms;

  ppg_heartbeat_rate_detector DUT (
    .clk(clk), .rst(rst), .samples(smp), .results(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    smp.valid = 0;
    smp.green_sample = 0;
    smp.time_ms = 0;
    smp.restart = 0;
    res.ready = 0;
    stall_left = 0;
  end

  // Receiver side: random stalls until the calm tail of the run.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      res.ready <= 0;
      stall_left <= $urandom_range(1, 18);
    end else begin
      res.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) sb.check_result(res.beat, res.rate_valid, res.smoothed_bpm);
  end

  task automatic write_reg(hbr_reg_t idx, logic [17:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic configure(logic [15:0] lpc, logic [15:0] hpc, logic [17:0] pk,
                           logic [15:0] refr, logic [15:0] mn, logic [15:0] mx,
                           logic [7:0] lo, logic [7:0] hi);
    write_reg(REG_LOWPASS_COEFF, lpc);
    write_reg(REG_HIGHPASS_COEFF, hpc);
    write_reg(REG_MIN_PEAK, pk);
    write_reg(REG_REFRACTORY, refr);
    write_reg(REG_MIN_INTERVAL, mn);
    write_reg(REG_MAX_INTERVAL, mx);
    write_reg(REG_MIN_VALID_BPM, lo);
    write_reg(REG_MAX_VALID_BPM, hi);
  endtask

  task automatic push_sample(logic [17:0] green, logic [31:0] now, logic restart);
    if (!calm && $urandom_range(0, 9) == 0) begin
      smp.valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    smp.valid <= 1;
    smp.green_sample <= green;
    smp.time_ms <= now;
    smp.restart <= restart;
    do @(posedge clk); while (!smp.ready);
    sb.note_sample(green, now, restart);
    sent++;
    calm = (sent > 1400);
  endtask

  // The sender holds off until the block has returned every pending result.
  task automatic drain();
    smp.valid <= 0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic pulse_train(int count);
    int unsigned period, amp, base, step, noise, ph, wave, v;
    period = $urandom_range(350, 1800);
    amp = $urandom_range(500, 40000);
    base = $urandom_range(amp, 262143 - amp);
    step = $urandom_range(8, 20);
    noise = $urandom_range(0, 200);
    if ($urandom_range(0, 7) == 0) clock_ms = 32'hffffffff - $urandom_range(0, 3000);
    for (int i = 0; i < count; i++) begin
      ph = clock_ms % period;
      wave = (ph < period / 2) ? 2 * ph : 2 * (period - ph);
      v = base - amp + (2 * amp * wave) / period + $urandom_range(0, noise);
      if (v > 262143) v = 262143;
      push_sample(v[17:0], clock_ms, $urandom_range(0, 299) == 0);
      clock_ms += step;
    end
  endtask

  task automatic random_phase(int quota);
    int start;
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        pulse_train($urandom_range(20, 120));
      end else begin
        repeat ($urandom_range(1, 10))
          push_sample(18'($urandom_range(0, 262143)), $urandom(), $urandom_range(0, 7) == 0);
      end
    end
    drain();
  endtask

  initial begin
    sb.reset_all();
    clock_ms = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, a sharp step that yields a beat, restart and time wrap.
    push_sample(0, 0, 0);
    push_sample(18'h3ffff, 1, 0);
    for (int i = 0; i < 4; i++) push_sample(18'h3ffff, 500 + 10 * i, 0);
    for (int i = 0; i < 4; i++) push_sample(0, 600 + 10 * i, 0);
    push_sample(18'h3ffff, 32'hffffffff, 0);
    push_sample(0, 32'h00000005, 0);
    push_sample(18'h2aaaa, 32'h80000000, 1);
    push_sample(18'h15555, 32'h7fffffff, 0);
    for (int i = 0; i < 4; i++) push_sample(18'h3ffff, 32'hfffffe00 + 10 * i, 0);
    for (int i = 0; i < 4; i++) push_sample(0, 32'h00000100 + 10 * i, 0);
    drain();

    configure(15667, 63540, 40, 300, 300, 2000, 30, 200);
    random_phase(230);
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    random_phase(150);
    configure(16'hffff, 16'hffff, 18'h3ffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
    random_phase(150);
    configure(16'hffff, 50000, 0, 0, 0, 16'hffff, 0, 8'hff);
    random_phase(250);
    for (int k = 0; k < 2; k++) begin
      configure(16'($urandom_range(2000, 65535)), 16'($urandom_range(40000, 65535)),
                18'($urandom_range(0, 300)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 600)), 16'($urandom_range(600, 65535)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase(250);
    end
    configure(15667, 63540, 40, 300, 300, 2000, 30, 200);
    random_phase(300);

    $display("%0d samples checked, %0d beats, %0d with a valid rate, %0d mismatches",
             sb.results_seen, sb.beats_seen, sb.valid_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end
endmodule
